>>> rtl/csbb_pkg.sv
// Shared widths, payload types and constants for the circular sector bounding box.
package csbb_pkg;

	localparam int SineTableBitsDefault = 10;

	localparam int CoordW  = 24;
	localparam int RadiusW = 20;
	localparam int AngleW  = 16;
	localparam int SpreadW = 17;
	localparam int BoxW    = 25;
	localparam int OffsetW = 21;
	localparam int SineW   = 16;
	localparam int ScaledW = 22;
	localparam int ProductW = 37;
	localparam int HalfShift = 15;

	localparam int SineMax = 32767;
	localparam real HalfPi = 1.5707963267948966;

	typedef logic signed [CoordW-1:0]  coord_t;
	typedef logic        [RadiusW-1:0] radius_t;
	typedef logic        [AngleW-1:0]  angle_t;
	typedef logic        [SpreadW-1:0] spread_t;
	typedef logic signed [BoxW-1:0]    box_t;
	typedef logic signed [OffsetW-1:0] offset_t;
	typedef logic signed [SineW-1:0]   sine_t;
	typedef logic signed [ScaledW-1:0] scaled_t;

	localparam angle_t QuarterTurn = angle_t'(16384);

endpackage

>>> rtl/csbb_in_if.sv
// Input channel carrying one light sector per transaction.
interface csbb_in_if import csbb_pkg::*;;
	logic    valid;
	logic    ready;
	coord_t  center_x;
	coord_t  center_y;
	radius_t radius;
	angle_t  direction_angle;
	spread_t spread_angle;

	modport source (
		output valid, center_x, center_y, radius, direction_angle, spread_angle,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, radius, direction_angle, spread_angle,
		output ready
	);
endinterface

>>> rtl/csbb_out_if.sv
// Output channel carrying one bounding box and its centre offset per transaction.
interface csbb_out_if import csbb_pkg::*;;
	logic    valid;
	logic    ready;
	box_t    lower_x;
	box_t    lower_y;
	box_t    upper_x;
	box_t    upper_y;
	offset_t offset_x;
	offset_t offset_y;

	modport source (
		output valid, lower_x, lower_y, upper_x, upper_y, offset_x, offset_y,
		input  ready
	);
	modport sink (
		input  valid, lower_x, lower_y, upper_x, upper_y, offset_x, offset_y,
		output ready
	);
endinterface

>>> rtl/csbb_sine_rom.sv
// Constant sine table with registered sine and cosine reads for one angle.
module csbb_sine_rom import csbb_pkg::*; #(
	parameter int SINE_TABLE_BITS = SineTableBitsDefault
) (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output sine_t  sin_val,
	output sine_t  cos_val
);

	localparam int  TableSize    = 1 << SINE_TABLE_BITS;
	localparam int  QuarterShift = SINE_TABLE_BITS - 2;
	localparam int  QuarterSize  = 1 << QuarterShift;
	localparam real QuarterStep  = HalfPi / real'(QuarterSize);

	typedef sine_t rom_t [TableSize];

	// Rounded first-quadrant sine, m runs from 0 to a full quarter.
	function automatic sine_t quarter_sine(int m);
		real x;
		real v;
		int  k;
		x = QuarterStep * real'(m);
		v = real'(SineMax) * $sin(x);
		k = $rtoi(v + 0.5);
		if (k > SineMax) begin
			k = SineMax;
		end
		return sine_t'(k);
	endfunction

	// The other quadrants are mirrored from the first so that symmetry is exact.
	function automatic rom_t build_rom();
		rom_t  rom;
		int    quad;
		int    q;
		sine_t v;
		for (int k = 0; k < TableSize; k++) begin
			quad = k >> QuarterShift;
			q    = k & (QuarterSize - 1);
			v    = quarter_sine(quad[0] ? (QuarterSize - q) : q);
			rom[k] = (quad >= 2) ? -v : v;
		end
		return rom;
	endfunction

	localparam rom_t SineRom = build_rom();

	angle_t                     cos_angle;
	logic [SINE_TABLE_BITS-1:0] sin_idx;
	logic [SINE_TABLE_BITS-1:0] cos_idx;

	assign cos_angle = angle + QuarterTurn;
	assign sin_idx   = angle[AngleW-1 -: SINE_TABLE_BITS];
	assign cos_idx   = cos_angle[AngleW-1 -: SINE_TABLE_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= SineRom[sin_idx];
			cos_val <= SineRom[cos_idx];
		end
	end

endmodule

>>> rtl/csbb_scale.sv
// Registered radius times sine product, rounded half up and shifted down by 15.
module csbb_scale import csbb_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  radius_t radius,
	input  sine_t   factor,
	output scaled_t scaled
);

	logic signed [RadiusW:0]    radius_s;
	logic signed [ProductW-1:0] product;
	logic signed [ProductW-1:0] rounded;

	assign radius_s = {1'b0, radius};
	assign product  = ProductW'(radius_s) * ProductW'(factor);
	assign rounded  = product + ProductW'(1 << (HalfShift - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			scaled <= rounded[HalfShift +: ScaledW];
		end
	end

endmodule

>>> rtl/circular_sector_bounding_box.sv
// Top level: axis-aligned bounding box of a circular light sector, six-stage pipeline.
//
//   Channel  Modport  Transaction carries
//   sector   sink     center_x, center_y, radius, direction_angle, spread_angle
//   box      source   lower_x, lower_y, upper_x, upper_y, offset_x, offset_y
//
// One sector is taken every cycle unless the output stalls; each passes through the stages in order.
// Stages: edge angles and axis tests, sine table read, radius products,
// circle points, min/max of the box, centre offset into the output register.
// arst_n clears the stage valid bits only; the pipeline is empty after reset.
// When the output holds a box that is not taken, every stage freezes together,
// so nothing is dropped or repeated.
module circular_sector_bounding_box import csbb_pkg::*; #(
	parameter int SINE_TABLE_BITS = SineTableBitsDefault
) (
	input logic       clk,
	input logic       arst_n,
	csbb_in_if.sink   sector,
	csbb_out_if.source box
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en           = !v_s6 || box.ready;
	assign sector.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= sector.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: edge angles, full-circle flag and quarter-turn axis tests.
	logic [SpreadW:0]   spread_plus;
	angle_t             start_angle;
	angle_t             stop_angle;
	logic [SpreadW-1:0] lo2;
	logic [SpreadW-1:0] axis_diff [4];
	logic [3:0]         axis_in;

	always_comb begin
		spread_plus = {1'b0, sector.spread_angle} + 1'b1;
		start_angle = sector.direction_angle - spread_plus[AngleW:1];
		stop_angle  = sector.direction_angle + sector.spread_angle[AngleW:1];
		lo2         = {sector.direction_angle, 1'b0} - sector.spread_angle;
		for (int a = 0; a < 4; a++) begin
			axis_diff[a] = (SpreadW'(a) << (AngleW - 1)) - lo2;
			axis_in[a]   = axis_diff[a] <= sector.spread_angle;
		end
	end

	coord_t     cx_s1, cy_s1;
	radius_t    r_s1;
	angle_t     start_s1, stop_s1;
	logic       full_s1;
	logic [3:0] axis_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1    <= sector.center_x;
			cy_s1    <= sector.center_y;
			r_s1     <= sector.radius;
			start_s1 <= start_angle;
			stop_s1  <= stop_angle;
			full_s1  <= (sector.spread_angle == '0) || sector.spread_angle[AngleW];
			axis_s1  <= axis_in;
		end
	end

	// Stage 2: sine table reads for both edges.
	sine_t start_sin_s2, start_cos_s2, stop_sin_s2, stop_cos_s2;

	csbb_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_start (
		.clk     (clk),
		.en      (en),
		.angle   (start_s1),
		.sin_val (start_sin_s2),
		.cos_val (start_cos_s2)
	);

	csbb_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_stop (
		.clk     (clk),
		.en      (en),
		.angle   (stop_s1),
		.sin_val (stop_sin_s2),
		.cos_val (stop_cos_s2)
	);

	coord_t     cx_s2, cy_s2;
	radius_t    r_s2;
	logic       full_s2;
	logic [3:0] axis_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			r_s2    <= r_s1;
			full_s2 <= full_s1;
			axis_s2 <= axis_s1;
		end
	end

	// Stage 3: radius products. The axis points use the full-scale table value.
	scaled_t start_dx_s3, start_dy_s3, stop_dx_s3, stop_dy_s3, axis_pos_s3, axis_neg_s3;

	csbb_scale u_scale_start_x (.clk(clk), .en(en), .radius(r_s2), .factor(start_cos_s2),
		.scaled(start_dx_s3));
	csbb_scale u_scale_start_y (.clk(clk), .en(en), .radius(r_s2), .factor(start_sin_s2),
		.scaled(start_dy_s3));
	csbb_scale u_scale_stop_x (.clk(clk), .en(en), .radius(r_s2), .factor(stop_cos_s2),
		.scaled(stop_dx_s3));
	csbb_scale u_scale_stop_y (.clk(clk), .en(en), .radius(r_s2), .factor(stop_sin_s2),
		.scaled(stop_dy_s3));
	csbb_scale u_scale_axis_pos (.clk(clk), .en(en), .radius(r_s2), .factor(sine_t'(SineMax)),
		.scaled(axis_pos_s3));
	csbb_scale u_scale_axis_neg (.clk(clk), .en(en), .radius(r_s2),
		.factor(sine_t'(-SineMax)), .scaled(axis_neg_s3));

	coord_t     cx_s3, cy_s3;
	radius_t    r_s3;
	logic       full_s3;
	logic [3:0] axis_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			r_s3    <= r_s2;
			full_s3 <= full_s2;
			axis_s3 <= axis_s2;
		end
	end

	// Stage 4: points on the circle relative to the plane.
	box_t       start_x_s4, start_y_s4, stop_x_s4, stop_y_s4;
	box_t       pos_x_s4, neg_x_s4, pos_y_s4, neg_y_s4;
	box_t       cx_s4, cy_s4;
	radius_t    r_s4;
	logic       full_s4;
	logic [3:0] axis_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			start_x_s4 <= BoxW'(cx_s3) + BoxW'(start_dx_s3);
			start_y_s4 <= BoxW'(cy_s3) + BoxW'(start_dy_s3);
			stop_x_s4  <= BoxW'(cx_s3) + BoxW'(stop_dx_s3);
			stop_y_s4  <= BoxW'(cy_s3) + BoxW'(stop_dy_s3);
			pos_x_s4   <= BoxW'(cx_s3) + BoxW'(axis_pos_s3);
			neg_x_s4   <= BoxW'(cx_s3) + BoxW'(axis_neg_s3);
			pos_y_s4   <= BoxW'(cy_s3) + BoxW'(axis_pos_s3);
			neg_y_s4   <= BoxW'(cy_s3) + BoxW'(axis_neg_s3);
			cx_s4      <= BoxW'(cx_s3);
			cy_s4      <= BoxW'(cy_s3);
			r_s4       <= r_s3;
			full_s4    <= full_s3;
			axis_s4    <= axis_s3;
		end
	end

	// Stage 5: the box. Axis points on the other coordinate equal the centre, so
	// each bound only needs the one axis that points its way.
	function automatic box_t box_min(box_t a, box_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic box_t box_max(box_t a, box_t b);
		return (a > b) ? a : b;
	endfunction

	box_t r_ext;
	box_t lx_next, ly_next, ux_next, uy_next;

	always_comb begin
		r_ext = BoxW'(r_s4);
		if (full_s4) begin
			lx_next = cx_s4 - r_ext;
			ly_next = cy_s4 - r_ext;
			ux_next = cx_s4 + r_ext;
			uy_next = cy_s4 + r_ext;
		end else begin
			ux_next = box_max(box_max(cx_s4, start_x_s4),
				box_max(stop_x_s4, axis_s4[0] ? pos_x_s4 : cx_s4));
			uy_next = box_max(box_max(cy_s4, start_y_s4),
				box_max(stop_y_s4, axis_s4[1] ? pos_y_s4 : cy_s4));
			lx_next = box_min(box_min(cx_s4, start_x_s4),
				box_min(stop_x_s4, axis_s4[2] ? neg_x_s4 : cx_s4));
			ly_next = box_min(box_min(cy_s4, start_y_s4),
				box_min(stop_y_s4, axis_s4[3] ? neg_y_s4 : cy_s4));
		end
	end

	box_t lx_s5, ly_s5, ux_s5, uy_s5;
	box_t cx_s5, cy_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s5 <= lx_next;
			ly_s5 <= ly_next;
			ux_s5 <= ux_next;
			uy_s5 <= uy_next;
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;
		end
	end

	// Stage 6: centre offset, floor of the halved sum minus the light centre.
	logic signed [BoxW:0] sum_x, sum_y;
	box_t                 diff_x, diff_y;

	assign sum_x  = (BoxW+1)'(lx_s5) + (BoxW+1)'(ux_s5);
	assign sum_y  = (BoxW+1)'(ly_s5) + (BoxW+1)'(uy_s5);
	assign diff_x = sum_x[BoxW:1] - cx_s5;
	assign diff_y = sum_y[BoxW:1] - cy_s5;

	box_t    lx_s6, ly_s6, ux_s6, uy_s6;
	offset_t ox_s6, oy_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s6 <= lx_s5;
			ly_s6 <= ly_s5;
			ux_s6 <= ux_s5;
			uy_s6 <= uy_s5;
			ox_s6 <= diff_x[OffsetW-1:0];
			oy_s6 <= diff_y[OffsetW-1:0];
		end
	end

	assign box.valid    = v_s6;
	assign box.lower_x  = lx_s6;
	assign box.lower_y  = ly_s6;
	assign box.upper_x  = ux_s6;
	assign box.upper_y  = uy_s6;
	assign box.offset_x = ox_s6;
	assign box.offset_y = oy_s6;

`ifndef NO_ASSERTIONS
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid |-> (box.lower_x <= box.upper_x) && (box.lower_y <= box.upper_y))
		else $error("bounding box has a lower corner above its upper corner");

	a_center_inside: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (lx_s5 <= cx_s5) && (cx_s5 <= ux_s5) && (ly_s5 <= cy_s5) && (cy_s5 <= uy_s5))
		else $error("light centre lies outside its bounding box");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en) |=> v_s5 && $stable(lx_s5) && $stable(uy_s5))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule

>>> bench/csbb_checker.sv
`timescale 1ns / 100ps
// Watches both channels, predicts each bounding box and compares it with what the block gives.
module csbb_checker import csbb_pkg::*; #(
	parameter int TABLE_BITS = SineTableBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	csbb_in_if   sector,
	csbb_out_if  box,
	output int   mismatches,
	output int   boxes_due
);

	localparam int  TableSize   = 1 << TABLE_BITS;
	localparam int  QuarterBits = TABLE_BITS - 2;
	localparam int  QuarterSize = 1 << QuarterBits;
	localparam real QuarterArc  = 1.5707963267948966;
	localparam real SineScale   = 32767.0;
	localparam longint unsigned FullTurn   = 65536;
	localparam longint unsigned TwoTurns   = 131072;
	localparam longint unsigned AngleMask  = 16'hFFFF;
	localparam longint unsigned DoubleMask = 17'h1FFFF;

	typedef struct packed {
		box_t    lower_x;
		box_t    lower_y;
		box_t    upper_x;
		box_t    upper_y;
		offset_t offset_x;
		offset_t offset_y;
	} box_result_t;

	sine_t       sine_lut [TableSize];
	box_result_t expected_boxes [$];
	box_result_t want;
	box_result_t got;

	// The table is filled one quadrant at a time so that it keeps the exact symmetry of a
	// rounded quarter wave.
	initial begin
		int  k;
		int  quad;
		int  m;
		int  v;
		for (k = 0; k < TableSize; k++) begin
			quad = k >> QuarterBits;
			m = k & (QuarterSize - 1);
			if (quad & 1)
				m = QuarterSize - m;
			v = $rtoi(SineScale * $sin(QuarterArc * m / QuarterSize) + 0.5);
			sine_lut[k] = (quad >= 2) ? sine_t'(-v) : sine_t'(v);
		end
	end

	// Radius times the table entry at the angle, scaled back by 2^15 with rounding half up.
	function automatic longint radial_offset(longint r, angle_t a);
		longint t;
		t = sine_lut[int'(a) >> (AngleW - TABLE_BITS)];
		return (r * t + 16384) >>> 15;
	endfunction

	function automatic box_result_t predict_box(coord_t cx_in, coord_t cy_in, radius_t rad,
			angle_t dir, spread_t spr);
		longint          cx, cy, r, lx, ly, ux, uy, px, py, ox, oy;
		longint unsigned d, s, lo2, diff;
		angle_t          pts [6];
		bit              hit [6];
		int              k;
		box_result_t     res;
		cx = cx_in;
		cy = cy_in;
		r  = rad;
		d  = dir;
		s  = spr;
		if (s == 0 || s >= FullTurn) begin
			lx = cx - r;
			ly = cy - r;
			ux = cx + r;
			uy = cy + r;
		end else begin
			pts[0] = angle_t'((d + TwoTurns - ((s + 1) >> 1)) & AngleMask);
			pts[1] = angle_t'((d + (s >> 1)) & AngleMask);
			hit[0] = 1'b1;
			hit[1] = 1'b1;
			// An axis counts when it lies within the sector, taken modulo one turn.
			lo2 = (2 * d + TwoTurns - s) & DoubleMask;
			for (k = 0; k < 4; k++) begin
				diff = (longint'(k) * 32768 + TwoTurns - lo2) & DoubleMask;
				pts[k + 2] = angle_t'(k * 16384);
				hit[k + 2] = (diff <= s);
			end
			lx = cx;
			ux = cx;
			ly = cy;
			uy = cy;
			for (k = 0; k < 6; k++) begin
				if (hit[k]) begin
					px = cx + radial_offset(r, pts[k] + QuarterTurn);
					py = cy + radial_offset(r, pts[k]);
					if (px < lx) lx = px;
					if (py < ly) ly = py;
					if (px > ux) ux = px;
					if (py > uy) uy = py;
				end
			end
		end
		ox = ((lx + ux) >>> 1) - cx;
		oy = ((ly + uy) >>> 1) - cy;
		res.lower_x  = box_t'(lx);
		res.lower_y  = box_t'(ly);
		res.upper_x  = box_t'(ux);
		res.upper_y  = box_t'(uy);
		res.offset_x = offset_t'(ox);
		res.offset_y = offset_t'(oy);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input longint seen, input longint wanted);
		if (seen != wanted)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, seen, wanted));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			mismatches = 0;
			boxes_due <= 0;
			expected_boxes.delete();
		end else begin
			// A box cannot leave in the cycle its sector enters, so the oldest is taken first.
			if (box.valid && box.ready) begin
				got.lower_x  = box.lower_x;
				got.lower_y  = box.lower_y;
				got.upper_x  = box.upper_x;
				got.upper_y  = box.upper_y;
				got.offset_x = box.offset_x;
				got.offset_y = box.offset_y;
				if (expected_boxes.size() == 0) begin
					report_mismatch("box transaction with no sector outstanding");
				end else begin
					want = expected_boxes.pop_front();
					compare_field("lower_x", got.lower_x, want.lower_x);
					compare_field("lower_y", got.lower_y, want.lower_y);
					compare_field("upper_x", got.upper_x, want.upper_x);
					compare_field("upper_y", got.upper_y, want.upper_y);
					compare_field("offset_x", got.offset_x, want.offset_x);
					compare_field("offset_y", got.offset_y, want.offset_y);
				end
			end
			if (sector.valid && sector.ready)
				expected_boxes.insert(expected_boxes.size(), predict_box(sector.center_x,
					sector.center_y, sector.radius, sector.direction_angle,
					sector.spread_angle));
			boxes_due <= expected_boxes.size();
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bench: clock, reset, sector stimulus, box back-pressure and the verdict.
module testbench;
	import csbb_pkg::*;

	localparam int TableBits   = SineTableBitsDefault;
	localparam int RandomCount = 632;
	localparam int TailCount   = 100;
	localparam int CycleLimit  = 100000;
	localparam int SettleCycles = 20;
	localparam int StallStart  = 400;
	localparam int StallLength = 250;

	localparam coord_t  CoordMin  = coord_t'(-8388608);
	localparam coord_t  CoordMax  = coord_t'(8388607);
	localparam radius_t RadiusMax = radius_t'(20'hFFFFF);

	typedef struct {
		coord_t  cx;
		coord_t  cy;
		radius_t r;
		angle_t  dir;
		spread_t spr;
	} sector_item_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   boxes_due;
	int   cycle_count;
	bit   steady_tail;

	sector_item_t sectors [$];

	csbb_in_if  sector_ch ();
	csbb_out_if box_ch ();

	circular_sector_bounding_box #(.SINE_TABLE_BITS(TableBits)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sector (sector_ch.sink),
		.box    (box_ch.source)
	);

	csbb_checker #(.TABLE_BITS(TableBits)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.sector     (sector_ch),
		.box        (box_ch),
		.mismatches (mismatches),
		.boxes_due  (boxes_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sector_item_t make_sector(coord_t cx, coord_t cy, radius_t r,
			angle_t dir, spread_t spr);
		sector_item_t s;
		s.cx = cx;
		s.cy = cy;
		s.r = r;
		s.dir = dir;
		s.spr = spr;
		return s;
	endfunction

	function automatic void add_sector(sector_item_t s);
		sectors.insert(sectors.size(), s);
	endfunction

	function automatic sector_item_t random_sector();
		sector_item_t s;
		s.cx = coord_t'($urandom);
		s.cy = coord_t'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			s.cx = coord_t'($signed(s.cx) >>> $urandom_range(0, 23));
			s.cy = coord_t'($signed(s.cy) >>> $urandom_range(0, 23));
		end
		s.r = radius_t'($urandom) & radius_t'((1 << $urandom_range(0, 20)) - 1);
		s.dir = angle_t'($urandom);
		// Directions near an axis make the axis test fall close to the sector edges.
		if ($urandom_range(0, 3) == 0)
			s.dir = angle_t'($urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4);
		case ($urandom_range(0, 9))
			0: s.spr = spread_t'(0);
			1: s.spr = spread_t'($urandom_range(65536, 131071));
			2: s.spr = spread_t'($urandom_range(1, 64));
			3: s.spr = spread_t'($urandom_range(1, 3) * 16384 + $urandom_range(0, 8) - 4);
			4: s.spr = spread_t'($urandom_range(65500, 65535));
			default: s.spr = spread_t'($urandom_range(1, 65535));
		endcase
		return s;
	endfunction

	initial begin
		sector_ch.valid           <= 1'b0;
		sector_ch.center_x        <= '0;
		sector_ch.center_y        <= '0;
		sector_ch.radius          <= '0;
		sector_ch.direction_angle <= '0;
		sector_ch.spread_angle    <= '0;
		arst_n                    <= 1'b0;
		steady_tail = 1'b0;

		// Full circles at the extremes, the narrowest and widest sectors, spreads of one
		// turn and beyond, axes on the edges, sectors across angle zero and across pi.
		add_sector(make_sector(0, 0, 0, 0, 0));
		add_sector(make_sector(CoordMax, CoordMax, RadiusMax, 0, 0));
		add_sector(make_sector(CoordMin, CoordMin, RadiusMax, 16'hFFFF, 17'd65536));
		add_sector(make_sector(CoordMin, CoordMax, RadiusMax, 12345, 17'h1FFFF));
		add_sector(make_sector(0, 0, RadiusMax, 0, 1));
		add_sector(make_sector(0, 0, RadiusMax, 0, 2));
		add_sector(make_sector(0, 0, RadiusMax, 16'hFFFF, 17'd65535));
		add_sector(make_sector(100, -100, RadiusMax, 8192, 16384));
		add_sector(make_sector(0, 0, RadiusMax, 16384, 32768));
		add_sector(make_sector(0, 0, RadiusMax, 32768, 3));
		add_sector(make_sector(0, 0, RadiusMax, 49152, 65534));
		add_sector(make_sector(CoordMax, CoordMin, RadiusMax, 0, 32768));
		add_sector(make_sector(0, 0, 1, 16383, 2));
		add_sector(make_sector(CoordMin, CoordMin, RadiusMax, 32768, 1));
		add_sector(make_sector(CoordMax, CoordMax, RadiusMax, 0, 16385));
		add_sector(make_sector(0, 0, 0, 12345, 777));
		add_sector(make_sector(0, 0, RadiusMax, 24576, 49151));
		add_sector(make_sector(-1, -1, RadiusMax, 40000, 65537));
		repeat (RandomCount) add_sector(random_sector());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (sectors[i]) begin
			if (i >= sectors.size() - TailCount)
				steady_tail = 1'b1;
			if (!steady_tail && !(i >= 300 && i < 360) && $urandom_range(0, 3) == 0) begin
				sector_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			sector_ch.valid           <= 1'b1;
			sector_ch.center_x        <= sectors[i].cx;
			sector_ch.center_y        <= sectors[i].cy;
			sector_ch.radius          <= sectors[i].r;
			sector_ch.direction_angle <= sectors[i].dir;
			sector_ch.spread_angle    <= sectors[i].spr;
			do @(posedge clk); while (!sector_ch.ready);
		end
		sector_ch.valid <= 1'b0;

		@(posedge clk);
		while (boxes_due != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0 && boxes_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Box side: random hold-offs, one long stall that lets the pipeline fill, none at the end.
	initial begin
		int rx_cycles;
		rx_cycles = 0;
		box_ch.ready <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles == StallStart) begin
				box_ch.ready <= 1'b0;
				repeat (StallLength) @(posedge clk);
				box_ch.ready <= 1'b1;
			end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
				box_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				box_ch.ready <= 1'b1;
			end else begin
				box_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/csbb_pkg.sv
rtl/csbb_in_if.sv
rtl/csbb_out_if.sv
rtl/csbb_sine_rom.sv
rtl/csbb_scale.sv
rtl/circular_sector_bounding_box.sv
bench/csbb_checker.sv
bench/testbench.sv
